// File: sv/btn_pkg.sv
// ----------------------------------------------------------------------------
// btn_pkg
// Shared types, constants, character-class, UTF-8 encode and case-fold
// functions of the text normalizer.
// ----------------------------------------------------------------------------
package btn_pkg;

  localparam int QUEUE_DEPTH   = 4;
  localparam int FRONT_MAX_OPS = 5;
  localparam int BACK_MAX_RES  = 6;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

  // One codepoint job, or a word close request, handed from front to back.
  typedef struct packed {
    logic        close;
    logic [20:0] cp;
    logic        last;
  } op_t;

  // One result item before the last-of-run flag is known.
  typedef struct packed {
    logic [7:0] data;
    logic       kind;
  } res_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
  } fold_t;

  function automatic logic is_space(input logic [20:0] c);
    return c inside {21'h20, 21'h09, 21'h0A, 21'h0D, 21'h0B, 21'h0C, 21'h85, 21'hA0,
                     21'h1680, [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
                     21'h205F, 21'h3000};
  endfunction

  function automatic logic is_control(input logic [20:0] c);
    logic r;
    r = c inside {[21'h00:21'h1F], 21'h7F, [21'h80:21'h9F], [21'h200B:21'h200F],
                  [21'h2060:21'h2064], 21'hFEFF};
    if (c inside {21'h09, 21'h0A, 21'h0D}) begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_punct(input logic [20:0] c);
    return c inside {[21'd33:21'd47], [21'd58:21'd64], [21'd91:21'd96], [21'd123:21'd126],
                     21'hA1, 21'hAB, 21'hB6, 21'hB7, 21'hBB, 21'hBF,
                     [21'h2010:21'h2027], [21'h2030:21'h205E], [21'h3001:21'h303F],
                     [21'hFE30:21'hFE4F], [21'hFF01:21'hFF0F], [21'hFF1A:21'hFF20],
                     [21'hFF3B:21'hFF40], [21'hFF5B:21'hFF65]};
  endfunction

  function automatic logic is_cjk(input logic [20:0] c);
    return c inside {[21'h4E00:21'h9FFF], [21'h3400:21'h4DBF], [21'hF900:21'hFAFF],
                     [21'h20000:21'h2A6DF], [21'h2A700:21'h2B73F], [21'h2B740:21'h2B81F],
                     [21'h2B820:21'h2CEAF], [21'h2F800:21'h2FA1F]};
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] c);
    utf8_t u;
    u = '0;
    if (c < 21'h80) begin
      u.len  = 3'd1;
      u.b[0] = c[7:0];
    end else if (c < 21'h800) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, c[10:6]};
      u.b[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, c[15:12]};
      u.b[1] = {2'b10, c[11:6]};
      u.b[2] = {2'b10, c[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, c[20:18]};
      u.b[1] = {2'b10, c[17:12]};
      u.b[2] = {2'b10, c[11:6]};
      u.b[3] = {2'b10, c[5:0]};
    end
    return u;
  endfunction

  function automatic fold_t fold_one(input logic [7:0] a);
    fold_t f;
    f.len = 2'd1;
    f.b0  = a;
    f.b1  = 8'h00;
    return f;
  endfunction

  function automatic fold_t fold_two(input logic [7:0] a, input logic [7:0] b);
    fold_t f;
    f.len = 2'd2;
    f.b0  = a;
    f.b1  = b;
    return f;
  endfunction

  // Case folding with accent stripping for ASCII, Latin-1 and Latin Extended-A.
  function automatic fold_t fold_cp(input logic [20:0] c);
    fold_t f;
    f = '0;
    if (c >= 21'h41 && c <= 21'h5A) begin
      f = fold_one(c[7:0] + 8'h20);
    end else if (c >= 21'hC0 && c <= 21'hFF) begin
      case (c[7:0]) inside
        8'hC6, 8'hE6:                              f = fold_two("a", "e");
        8'hC7, 8'hE7:                              f = fold_one("c");
        8'hD0, 8'hF0:                              f = fold_one("d");
        8'hD1, 8'hF1:                              f = fold_one("n");
        8'hD8, 8'hF8:                              f = fold_one("o");
        8'hDD, 8'hFD, 8'hFF:                       f = fold_one("y");
        8'hDE, 8'hFE:                              f = fold_two("t", "h");
        8'hDF:                                     f = fold_two("s", "s");
        [8'hC0:8'hC5], [8'hE0:8'hE5]:              f = fold_one("a");
        [8'hC8:8'hCB], [8'hE8:8'hEB]:              f = fold_one("e");
        [8'hCC:8'hCF], [8'hEC:8'hEF]:              f = fold_one("i");
        [8'hD2:8'hD6], [8'hF2:8'hF6]:              f = fold_one("o");
        [8'hD9:8'hDC], [8'hF9:8'hFC]:              f = fold_one("u");
        default:                                   f = '0;
      endcase
    end else if (c >= 21'h100 && c <= 21'h17F) begin
      if (c == 21'h132 || c == 21'h133)      f = fold_two("i", "j");
      else if (c == 21'h152 || c == 21'h153) f = fold_two("o", "e");
      else if (c <= 21'h105)                 f = fold_one("a");
      else if (c <= 21'h10D)                 f = fold_one("c");
      else if (c <= 21'h111)                 f = fold_one("d");
      else if (c <= 21'h11B)                 f = fold_one("e");
      else if (c <= 21'h123)                 f = fold_one("g");
      else if (c <= 21'h127)                 f = fold_one("h");
      else if (c <= 21'h131)                 f = fold_one("i");
      else if (c <= 21'h135)                 f = fold_one("j");
      else if (c <= 21'h138)                 f = fold_one("k");
      else if (c <= 21'h142)                 f = fold_one("l");
      else if (c <= 21'h14B)                 f = fold_one("n");
      else if (c <= 21'h151)                 f = fold_one("o");
      else if (c <= 21'h159)                 f = fold_one("r");
      else if (c <= 21'h161)                 f = fold_one("s");
      else if (c <= 21'h167)                 f = fold_one("t");
      else if (c <= 21'h173)                 f = fold_one("u");
      else if (c <= 21'h175)                 f = fold_one("w");
      else if (c <= 21'h178)                 f = fold_one("y");
      else if (c <= 21'h17E)                 f = fold_one("z");
      else                                   f = fold_one("s");
    end
    return f;
  endfunction

endpackage

// File: sv/btn_front.sv
// ----------------------------------------------------------------------------
// btn_front
// Lenient UTF-8 decoder: turns each input byte into a short list of codepoint
// and word-close jobs, pushed into the queue one per cycle while it has room.
// ----------------------------------------------------------------------------
module btn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            end_of_text,
  output logic            q_push,
  output btn_pkg::op_t    q_data,
  input  logic            q_full
);
  import btn_pkg::*;

  logic [7:0]  held [3];
  logic [1:0]  held_count;
  logic [2:0]  expected_length;
  logic [20:0] partial_codepoint;

  logic [7:0]  held_next [3];
  logic [1:0]  held_count_next;
  logic [2:0]  expected_length_next;
  logic [20:0] partial_codepoint_next;

  op_t        ops [FRONT_MAX_OPS];
  logic [2:0] op_cnt;
  logic [2:0] op_idx;

  op_t        ops_next [FRONT_MAX_OPS];
  logic [2:0] op_cnt_next;

  logic        accept;
  logic        busy;
  logic        do_start;
  logic [20:0] shifted;
  logic [2:0]  lead_len;

  assign busy     = (op_idx != op_cnt);
  assign q_push   = busy && !q_full;
  assign in_stall = !(!busy || (q_push && (op_idx + 3'd1 == op_cnt)));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    q_data      = ops[op_idx];
    q_data.last = (op_idx + 3'd1 == op_cnt);
  end

  always_comb begin
    if (in_byte < 8'h80)                 lead_len = 3'd1;
    else if (in_byte[7:5] == 3'b110)     lead_len = 3'd2;
    else if (in_byte[7:4] == 4'b1110)    lead_len = 3'd3;
    else if (in_byte[7:3] == 5'b11110)   lead_len = 3'd4;
    else                                 lead_len = 3'd1;
  end

  assign shifted = {partial_codepoint[14:0], in_byte[5:0]};

  always_comb begin
    for (int i = 0; i < FRONT_MAX_OPS; i++) begin
      ops_next[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      held_next[i] = held[i];
    end
    op_cnt_next            = 3'd0;
    held_count_next        = held_count;
    expected_length_next   = expected_length;
    partial_codepoint_next = partial_codepoint;
    do_start               = 1'b0;

    if (held_count == 2'd0) begin
      do_start = 1'b1;
    end else if (in_byte[7:6] == 2'b10) begin
      if ({1'b0, held_count} + 3'd1 >= expected_length) begin
        ops_next[op_cnt_next].cp = shifted;
        op_cnt_next              = op_cnt_next + 3'd1;
        held_count_next          = 2'd0;
        expected_length_next     = 3'd0;
        partial_codepoint_next   = '0;
      end else begin
        held_next[held_count]  = in_byte;
        held_count_next        = held_count + 2'd1;
        partial_codepoint_next = shifted;
      end
    end else begin
      // Broken sequence: every held byte becomes a codepoint of its own.
      for (int i = 0; i < 3; i++) begin
        if (i < held_count) begin
          ops_next[op_cnt_next].cp = {13'd0, held[i]};
          op_cnt_next              = op_cnt_next + 3'd1;
        end
      end
      held_count_next        = 2'd0;
      expected_length_next   = 3'd0;
      partial_codepoint_next = '0;
      do_start               = 1'b1;
    end

    if (do_start) begin
      if (lead_len == 3'd1) begin
        ops_next[op_cnt_next].cp = {13'd0, in_byte};
        op_cnt_next              = op_cnt_next + 3'd1;
      end else begin
        held_next[0]         = in_byte;
        held_count_next      = 2'd1;
        expected_length_next = lead_len;
        partial_codepoint_next = {13'd0, in_byte & (8'hFF >> (lead_len + 3'd1))};
      end
    end

    if (end_of_text) begin
      for (int i = 0; i < 3; i++) begin
        if (i < held_count_next) begin
          ops_next[op_cnt_next].cp = {13'd0, held_next[i]};
          op_cnt_next              = op_cnt_next + 3'd1;
        end
      end
      held_count_next             = 2'd0;
      expected_length_next        = 3'd0;
      partial_codepoint_next      = '0;
      ops_next[op_cnt_next].close = 1'b1;
      op_cnt_next                 = op_cnt_next + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count        <= 2'd0;
      expected_length   <= 3'd0;
      partial_codepoint <= '0;
      op_cnt            <= 3'd0;
      op_idx            <= 3'd0;
    end else if (accept) begin
      held_count        <= held_count_next;
      expected_length   <= expected_length_next;
      partial_codepoint <= partial_codepoint_next;
      op_cnt            <= op_cnt_next;
      op_idx            <= 3'd0;
    end else if (q_push) begin
      op_idx <= op_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
      ops  <= ops_next;
    end
  end

endmodule

// File: sv/btn_queue.sv
// ----------------------------------------------------------------------------
// btn_queue
// Small first-in first-out job queue between the decoder and the emitter.
// ----------------------------------------------------------------------------
module btn_queue #(
  parameter int DEPTH = btn_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  btn_pkg::op_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output btn_pkg::op_t pop_data
);
  import btn_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/btn_back.sv
// ----------------------------------------------------------------------------
// btn_back
// Classifies each codepoint job, folds or re-encodes it, and emits word bytes
// and word-end markers one per cycle unless stalled, tagging each run's last.
// ----------------------------------------------------------------------------
module btn_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         lowercase,
  input  logic         q_valid,
  input  btn_pkg::op_t q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic         kind,
  output logic         last_of_run
);
  import btn_pkg::*;

  res_t       list [BACK_MAX_RES];
  logic [2:0] res_cnt;
  logic [2:0] res_idx;
  logic       run_end;
  logic       word_open;

  res_t       list_next [BACK_MAX_RES];
  logic [2:0] res_cnt_next;
  logic       word_open_next;

  // Hold stage: newest result, waiting to learn whether it ends its run.
  res_t hold;
  logic hold_valid;
  logic hold_last;

  logic out_free;
  logic busy;
  logic emit_ok;
  logic emit;
  logic last_emit;
  logic final_emit;
  logic load;
  logic mark;
  logic hold_go;

  logic [20:0] c;
  utf8_t       enc;
  fold_t       fld;

  assign out_free   = !out_valid || !out_stall;
  assign busy       = (res_idx != res_cnt);
  assign emit_ok    = !hold_valid || out_free;
  assign emit       = busy && emit_ok;
  assign last_emit  = emit && (res_idx + 3'd1 == res_cnt);
  assign final_emit = run_end && (res_idx + 3'd1 == res_cnt);
  assign load       = q_valid && (!busy || last_emit);
  assign q_pop      = load;
  assign mark       = load && (res_cnt_next == 3'd0) && q_data.last;
  assign hold_go    = hold_valid && out_free && (hold_last || emit);

  assign c   = q_data.cp;
  assign enc = utf8_encode(c);
  assign fld = fold_cp(c);

  always_comb begin
    for (int i = 0; i < BACK_MAX_RES; i++) begin
      list_next[i] = '0;
    end
    res_cnt_next   = 3'd0;
    word_open_next = word_open;

    if (q_data.close) begin
      if (word_open) begin
        list_next[res_cnt_next].kind = KIND_END;
        res_cnt_next                 = res_cnt_next + 3'd1;
      end
      word_open_next = 1'b0;
    end else if (c == '0 || c == CP_REPLACEMENT || is_control(c)) begin
      word_open_next = word_open;
    end else if (is_space(c)) begin
      if (word_open) begin
        list_next[res_cnt_next].kind = KIND_END;
        res_cnt_next                 = res_cnt_next + 3'd1;
      end
      word_open_next = 1'b0;
    end else if (is_punct(c) || is_cjk(c)) begin
      if (word_open) begin
        list_next[res_cnt_next].kind = KIND_END;
        res_cnt_next                 = res_cnt_next + 3'd1;
      end
      for (int k = 0; k < 4; k++) begin
        if (k < enc.len) begin
          list_next[res_cnt_next].data = enc.b[k];
          res_cnt_next                 = res_cnt_next + 3'd1;
        end
      end
      list_next[res_cnt_next].kind = KIND_END;
      res_cnt_next                 = res_cnt_next + 3'd1;
      word_open_next               = 1'b0;
    end else if (lowercase && fld.len != 2'd0) begin
      list_next[0].data = fld.b0;
      list_next[1].data = fld.b1;
      res_cnt_next      = {1'b0, fld.len};
      word_open_next    = 1'b1;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (k < enc.len) begin
          list_next[res_cnt_next].data = enc.b[k];
          res_cnt_next                 = res_cnt_next + 3'd1;
        end
      end
      word_open_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt    <= 3'd0;
      res_idx    <= 3'd0;
      run_end    <= 1'b0;
      word_open  <= 1'b0;
      hold_valid <= 1'b0;
      hold_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        res_cnt   <= res_cnt_next;
        res_idx   <= 3'd0;
        run_end   <= q_data.last;
        word_open <= word_open_next;
      end else if (emit) begin
        res_idx <= res_idx + 3'd1;
      end

      if (emit) begin
        hold_valid <= 1'b1;
        hold_last  <= final_emit || mark;
      end else if (hold_go) begin
        hold_valid <= 1'b0;
      end else if (mark && hold_valid) begin
        hold_last <= 1'b1;
      end

      if (hold_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= list_next;
    end
    if (emit) begin
      hold <= list[res_idx];
    end
    if (hold_go) begin
      out_byte    <= hold.data;
      kind        <= hold.kind;
      last_of_run <= hold_last;
    end
  end

endmodule

// File: sv/bert_text_normalizer.sv
// ----------------------------------------------------------------------------
// bert_text_normalizer
// Byte-serial text normalizer: lenient UTF-8 decode, control and whitespace
// handling, punctuation and CJK splitting, optional case folding.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   in_byte, end_of_text
//   out       output     out_valid / out_stall out_byte, kind, last_of_run
//   config    input      lowercase_we          lowercase_wdata
//
// A text byte is decoded in the cycle it is taken; the decoder then pushes
// its jobs (codepoints and a word close at end of text) into the job queue
// at one per cycle while the queue has room. The emitter takes a new job
// when idle or as it passes on the last result of the job before, and it
// sends one output byte per cycle unless stalled, which sets the rate.
// Reset is synchronous; it empties the queue, drops any partial sequence and
// closes no word. A stall on the output backs up the queue and then the input
// without losing any transaction.
// ----------------------------------------------------------------------------
module bert_text_normalizer #(
  parameter int QUEUE_DEPTH = btn_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       lowercase_we,
  input  logic       lowercase_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       kind,
  output logic       last_of_run
);
  import btn_pkg::*;

  // The case-fold enable; it comes out of reset set.
  logic lowercase;

  logic q_push;
  op_t  q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  op_t  q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowercase <= 1'b1;
    end else if (lowercase_we) begin
      lowercase <= lowercase_wdata;
    end
  end

  // The front decodes bytes and never looks at word state.
  btn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .q_push      (q_push),
    .q_data      (q_push_data),
    .q_full      (q_full)
  );

  // The queue lets the decoder run ahead while the emitter drains long runs.
  btn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // The back owns the open-word flag and the output register.
  btn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .lowercase   (lowercase),
    .q_valid     (q_valid),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

endmodule

// File: tb/tb_bert_text_normalizer.sv
// ----------------------------------------------------------------------------
// tb_bert_text_normalizer
// Self-checking testbench for the byte-serial text normalizer. A behavioral
// normalizer in the testbench predicts the result stream of every accepted
// text byte. A checker compares each output transaction with the oldest
// predicted result, field by field.
// ----------------------------------------------------------------------------
module tb_bert_text_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  import btn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       lowercase_we = 1'b0;
  logic       lowercase_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       kind;
  logic       last_of_run;

  bert_text_normalizer uut (
    .clk(clk), .rst(rst),
    .lowercase_we(lowercase_we), .lowercase_wdata(lowercase_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .kind(kind), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // One predicted output transaction.
  typedef struct {
    logic [7:0] data;
    logic       knd;
    logic       last;
  } word_item_t;

  word_item_t pending_words[$];  // predicted results not yet seen on the output
  word_item_t run_words[$];      // results of the byte being predicted

  // Shadow copy of the normalizer's state.
  logic        fold_on;
  logic [7:0]  held[3];
  int          held_cnt;
  int          seq_need;
  logic [20:0] part_cp;
  logic        in_word;

  int  fail_count = 0;
  int  cycle_count = 0;
  // When set, neither side inserts idle cycles.
  bit  steady = 1'b0;

  // --------------------------------------------------------------------------
  // Character classes, written out range by range.
  // --------------------------------------------------------------------------
  function automatic bit cls_space(input int c);
    return c == 'h20 || (c >= 'h09 && c <= 'h0D) || c == 'h85 || c == 'hA0 ||
           c == 'h1680 || (c >= 'h2000 && c <= 'h200A) || c == 'h2028 ||
           c == 'h2029 || c == 'h202F || c == 'h205F || c == 'h3000;
  endfunction

  function automatic bit cls_ctrl(input int c);
    if (c == 'h09 || c == 'h0A || c == 'h0D) return 1'b0;
    return c < 'h20 || c == 'h7F || (c >= 'h80 && c <= 'h9F) ||
           (c >= 'h200B && c <= 'h200F) || (c >= 'h2060 && c <= 'h2064) || c == 'hFEFF;
  endfunction

  function automatic bit cls_punct(input int c);
    if (c < 'h80)
      return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) || (c >= 91 && c <= 96) ||
             (c >= 123 && c <= 126);
    return c == 'hA1 || c == 'hAB || c == 'hB6 || c == 'hB7 || c == 'hBB || c == 'hBF ||
           (c >= 'h2010 && c <= 'h2027) || (c >= 'h2030 && c <= 'h205E) ||
           (c >= 'h3001 && c <= 'h303F) || (c >= 'hFE30 && c <= 'hFE4F) ||
           (c >= 'hFF01 && c <= 'hFF0F) || (c >= 'hFF1A && c <= 'hFF20) ||
           (c >= 'hFF3B && c <= 'hFF40) || (c >= 'hFF5B && c <= 'hFF65);
  endfunction

  function automatic bit cls_ideo(input int c);
    return (c >= 'h4E00 && c <= 'h9FFF) || (c >= 'h3400 && c <= 'h4DBF) ||
           (c >= 'hF900 && c <= 'hFAFF) || (c >= 'h20000 && c <= 'h2A6DF) ||
           (c >= 'h2A700 && c <= 'h2CEAF) || (c >= 'h2F800 && c <= 'h2FA1F);
  endfunction

  // Returns the number of ASCII letters that a codepoint folds to, 0 if none.
  function automatic int latin_fold(input int c, output byte f0, output byte f1);
    string s;
    f0 = 0;
    f1 = 0;
    if (c >= 'h41 && c <= 'h5A) begin
      f0 = byte'(c + 'h20);
      return 1;
    end
    if (c < 'hC0 || c > 'h17F || c == 'hD7 || c == 'hF7) return 0;
    if (c <= 'hFF) begin
      case (c) inside
        'hC6, 'hE6: s = "ae";
        'hC7, 'hE7: s = "c";
        'hD0, 'hF0: s = "d";
        'hD1, 'hF1: s = "n";
        'hD8, 'hF8: s = "o";
        'hDD, 'hFD, 'hFF: s = "y";
        'hDE, 'hFE: s = "th";
        'hDF: s = "ss";
        ['hC0:'hC5], ['hE0:'hE5]: s = "a";
        ['hC8:'hCB], ['hE8:'hEB]: s = "e";
        ['hCC:'hCF], ['hEC:'hEF]: s = "i";
        ['hD2:'hD6], ['hF2:'hF6]: s = "o";
        default: s = "u";
      endcase
    end else if (c == 'h132 || c == 'h133) s = "ij";
    else if (c == 'h152 || c == 'h153) s = "oe";
    else if (c <= 'h105) s = "a";
    else if (c <= 'h10D) s = "c";
    else if (c <= 'h111) s = "d";
    else if (c <= 'h11B) s = "e";
    else if (c <= 'h123) s = "g";
    else if (c <= 'h127) s = "h";
    else if (c <= 'h131) s = "i";
    else if (c <= 'h135) s = "j";
    else if (c <= 'h138) s = "k";
    else if (c <= 'h142) s = "l";
    else if (c <= 'h14B) s = "n";
    else if (c <= 'h151) s = "o";
    else if (c <= 'h159) s = "r";
    else if (c <= 'h161) s = "s";
    else if (c <= 'h167) s = "t";
    else if (c <= 'h173) s = "u";
    else if (c <= 'h175) s = "w";
    else if (c <= 'h178) s = "y";
    else if (c <= 'h17E) s = "z";
    else s = "s";
    f0 = s[0];
    if (s.len() > 1) f1 = s[1];
    return s.len();
  endfunction

  // Canonical UTF-8 bytes of a 21-bit codepoint.
  function automatic void utf8_bytes(input int c, ref byte q[$]);
    c = c & 'h1FFFFF;
    q.delete();
    if (c < 'h80) begin
      q = {q, byte'(c)};
    end else if (c < 'h800) begin
      q = {q, byte'('hC0 | (c >> 6))};
      q = {q, byte'('h80 | (c & 'h3F))};
    end else if (c < 'h10000) begin
      q = {q, byte'('hE0 | (c >> 12))};
      q = {q, byte'('h80 | ((c >> 6) & 'h3F))};
      q = {q, byte'('h80 | (c & 'h3F))};
    end else begin
      q = {q, byte'('hF0 | (c >> 18))};
      q = {q, byte'('h80 | ((c >> 12) & 'h3F))};
      q = {q, byte'('h80 | ((c >> 6) & 'h3F))};
      q = {q, byte'('h80 | (c & 'h3F))};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Normalizer prediction.
  // --------------------------------------------------------------------------
  function automatic void add_word_item(input logic [7:0] d, input logic k);
    word_item_t w;
    w.data = d;
    w.knd  = k;
    w.last = 1'b0;
    run_words = {run_words, w};
  endfunction

  function automatic void end_word();
    if (in_word) begin
      add_word_item(8'h00, KIND_END);
      in_word = 1'b0;
    end
  endfunction

  function automatic void add_encoded(input int c);
    byte q[$];
    utf8_bytes(c, q);
    foreach (q[i]) add_word_item(q[i], KIND_TEXT);
  endfunction

  function automatic void normalize_cp(input int c);
    byte f0, f1;
    int  n;
    if (c == 0 || c == 'hFFFD || cls_ctrl(c)) return;
    if (cls_space(c)) begin
      end_word();
      return;
    end
    if (cls_punct(c) || cls_ideo(c)) begin
      // Punctuation and ideographs stand as words of their own.
      end_word();
      add_encoded(c);
      add_word_item(8'h00, KIND_END);
      return;
    end
    n = fold_on ? latin_fold(c, f0, f1) : 0;
    if (n > 0) begin
      add_word_item(f0, KIND_TEXT);
      if (n > 1) add_word_item(f1, KIND_TEXT);
    end else begin
      add_encoded(c);
    end
    in_word = 1'b1;
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held_cnt; i++) normalize_cp(held[i]);
    held_cnt = 0;
    seq_need = 0;
    part_cp  = '0;
  endfunction

  function automatic void begin_seq(input logic [7:0] b);
    int n;
    if (b[7] == 1'b0) n = 1;
    else if (b[7:5] == 3'b110) n = 2;
    else if (b[7:4] == 4'b1110) n = 3;
    else if (b[7:3] == 5'b11110) n = 4;
    else n = 1;
    if (n == 1) begin
      normalize_cp(b);
      return;
    end
    held[0]  = b;
    held_cnt = 1;
    seq_need = n;
    part_cp  = 21'(b & (8'hFF >> (n + 1)));
  endfunction

  // Predicts the results of one text byte and queues them for the checker.
  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    int c;
    run_words.delete();
    if (held_cnt == 0) begin
      begin_seq(b);
    end else if (b[7:6] == 2'b10) begin
      part_cp = {part_cp[14:0], b[5:0]};
      if (held_cnt + 1 >= seq_need) begin
        c = part_cp;
        held_cnt = 0;
        seq_need = 0;
        part_cp  = '0;
        normalize_cp(c);
      end else if (held_cnt < 3) begin
        held[held_cnt] = b;
        held_cnt++;
      end
    end else begin
      // A broken sequence: the held bytes go out one by one first.
      release_held();
      begin_seq(b);
    end
    if (eot) begin
      release_held();
      end_word();
    end
    if (run_words.size() > 0) run_words[$].last = 1'b1;
    pending_words = {pending_words, run_words};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tasks. Every task is entered and left right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eot = 1'b0);
    predict_byte(b, eot);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_cp(input int c, input logic eot = 1'b0);
    byte q[$];
    utf8_bytes(c, q);
    foreach (q[i]) send_byte(q[i], eot && i == q.size() - 1);
  endtask

  // Waits until every predicted result has been seen, then lets the block
  // finish any work that causes no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lowercase(input logic v);
    wait_drained();
    lowercase_we    <= 1'b1;
    lowercase_wdata <= v;
    @(posedge clk);
    lowercase_we    <= 1'b0;
    fold_on = v;
  endtask

  // A codepoint drawn from the interesting regions of the character map.
  function automatic int pick_cp();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range('h7F);
      3, 4:    return $urandom_range('h80, 'h17F);
      5:       return $urandom_range('h1FF0, 'h2070);
      6:       return $urandom_range('h2FF0, 'h303F);
      7:       return $urandom_range('h4DB0, 'h4E10);
      8:       return $urandom_range('hFE20, 'hFFFF);
      default: return $urandom_range('h10000, 'h1FFFFF);
    endcase
  endfunction

  // Mostly well-formed text, with noise bytes and cut-off sequences mixed in.
  task automatic random_text(input int n_items);
    int  sent = 0;
    int  cp;
    byte q[$];
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
          sent++;
        end
        1: begin
          utf8_bytes(pick_cp(), q);
          for (int i = 0; i < q.size() - 1; i++) send_byte(q[i]);
          sent += q.size() - 1;
        end
        default: begin
          cp = pick_cp();
          utf8_bytes(cp, q);
          send_cp(cp, $urandom_range(14) == 0);
          sent += q.size();
        end
      endcase
    end
  endtask

  // Extremes of both fields and every class of codepoint.
  task automatic test_directed();
    send_byte("A");
    send_byte("z");
    send_byte(" ");
    send_byte("!");
    send_byte(8'h00);
    send_byte(8'h7F);
    send_cp('hC9);        // accented capital letter
    send_cp('hDF);        // sharp s folds to two letters
    send_cp('h132);       // ligature of Latin Extended-A
    send_cp('h17F);
    send_cp('h4E00);      // ideograph
    send_cp('hFFFD);      // replacement character is dropped
    send_cp('h3000);      // ideographic space
    send_cp('h20000);     // ideograph beyond the basic plane
    send_byte(8'hE2);     // broken sequence: lead, continuation, then ASCII
    send_byte(8'h82);
    send_byte("x");
    send_byte(8'hA0);     // stray continuation bytes
    send_byte(8'h85);
    send_byte(8'hFF);
    send_byte(8'hF0);     // sequence cut short by the end of text
    send_byte(8'h9F, 1'b1);
  endtask

  task automatic test_no_folding();
    set_lowercase(1'b0);
    send_byte("Q");
    send_cp('hC6);
    send_cp('h14A, 1'b1);
    random_text(35);
    set_lowercase(1'b1);
  endtask

  task automatic test_random_idles();
    random_text(50);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    random_text(30);
    steady = 1'b0;
  endtask

  // The sender holds off until the block has delivered everything, then
  // resumes inside an open word.
  task automatic test_drain_pause();
    send_byte("k");
    send_byte(8'hC3);
    wait_drained();
    send_byte(8'h84);
    send_byte("m", 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall and the result checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !steady && !rst && $urandom_range(99) < 20;
  end

  always @(posedge clk) begin
    word_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result: out_byte=%h kind=%b", out_byte, kind);
        fail_count++;
      end else begin
        w = pending_words.pop_front();
        if (out_byte !== w.data) begin
          $error("out_byte: expected %h, got %h", w.data, out_byte);
          fail_count++;
        end
        if (kind !== w.knd) begin
          $error("kind: expected %b, got %b", w.knd, kind);
          fail_count++;
        end
        if (last_of_run !== w.last) begin
          $error("last_of_run: expected %b, got %b", w.last, last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bert_text_normalizer test failed");
      $finish;
    end
  end

  initial begin
    fold_on  = 1'b1;
    held_cnt = 0;
    seq_need = 0;
    part_cp  = '0;
    in_word  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_folding();
    test_random_idles();
    test_back_to_back();
    test_drain_pause();
    wait_drained();
    if (fail_count == 0) begin
      $display("bert_text_normalizer test passed");
    end else begin
      $display("bert_text_normalizer test failed");
    end
    $finish;
  end

endmodule

// File: bert_text_normalizer.f
sv/btn_pkg.sv
sv/btn_front.sv
sv/btn_queue.sv
sv/btn_back.sv
sv/bert_text_normalizer.sv
tb/tb_bert_text_normalizer.sv
